### hw/rtl/qcn_cp_pkg.sv
// qcn_cp_pkg: shared types and constants for the qcn congestion point
// register indexes, reset values, level quantizer bit positions and the sampler credit table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package qcn_cp_pkg;

  localparam int unsigned TARGET_W = 16;
  localparam int unsigned WEIGHT_W = 3;
  localparam int unsigned LEVEL_W  = 6;
  localparam int unsigned LEVEL_LSB = 13;
  localparam int unsigned CREDIT_W = 19;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned OUT_S_W  = 21;
  localparam int unsigned OUT_Q_W  = 20;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // register index is paddr[2]
  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_WEIGHT = 1'b1;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 16'd33792;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 3'd2;
  localparam logic [CREDIT_W-1:0] CREDIT_RESET = 19'd153600;

  localparam logic MODE_ARRIVAL   = 1'b0;
  localparam logic MODE_DEPARTURE = 1'b1;

  typedef struct packed {
    logic                valid;
    logic [LEVEL_W-1:0]  level;
  } fb_info_t;

  // credit reload, indexed by the top three bits of the level
  function automatic logic [CREDIT_W-1:0] credit_reload(input logic [2:0] idx);
    logic [CREDIT_W-1:0] c;
    case (idx)
      3'd0:    c = 19'd153600;
      3'd1:    c = 19'd76800;
      3'd2:    c = 19'd51200;
      3'd3:    c = 19'd38400;
      3'd4:    c = 19'd30720;
      3'd5:    c = 19'd25600;
      3'd6:    c = 19'd22016;
      3'd7:    c = 19'd18944;
      default: c = 19'd153600;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/qcn_congestion_point_unit.sv
// qcn congestion point on one egress queue: one packet event per cycle.
// a request is accepted every cycle while the 4-entry record queue has room;
// its result passes through the record queue, then the result register.
// throughput is set by the queue count and sampler update loop, which is not pipelined.
// rst (synchronous) clears the queue count, sample point, pending flag, queues,
// and loads credit 153600, target 33792 and weight 2; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module qcn_congestion_point_unit #(
  parameter int unsigned QUEUE_BYTE_BITS = 20
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // configuration
  input  wire logic                                    psel,
  input  wire logic                                    penable,
  input  wire logic                                    pwrite,
  input  wire logic [qcn_cp_pkg::PADDR_W-1:0]          paddr,
  input  wire logic [qcn_cp_pkg::PDATA_W-1:0]          pwdata,
  output logic      [qcn_cp_pkg::PDATA_W-1:0]          prdata,
  output logic                                         pready,
  // packet events
  input  wire logic                                    push,
  output logic                                         full,
  input  wire logic                                    mode,
  input  wire logic [qcn_cp_pkg::LEN_W-1:0]            packet_bytes,
  input  wire logic                                    is_ipv4,
  input  wire logic [qcn_cp_pkg::ADDR_W-1:0]           dest_addr,
  input  wire logic [qcn_cp_pkg::ADDR_W-1:0]           src_addr,
  // results
  output logic                                         empty,
  input  wire logic                                    pop,
  output logic                                         feedback_valid,
  output logic [qcn_cp_pkg::LEVEL_W-1:0]               feedback_level,
  output logic signed [qcn_cp_pkg::OUT_S_W-1:0]        queue_offset,
  output logic signed [qcn_cp_pkg::OUT_S_W-1:0]        queue_delta,
  output logic [qcn_cp_pkg::ADDR_W-1:0]                fb_dest_addr,
  output logic [qcn_cp_pkg::ADDR_W-1:0]                fb_src_addr,
  output logic [qcn_cp_pkg::OUT_Q_W-1:0]               queue_bytes_now
);

  localparam int unsigned QB     = QUEUE_BYTE_BITS;
  localparam int unsigned AW     = qcn_cp_pkg::ADDR_W;
  localparam int unsigned INFO_W = $bits(qcn_cp_pkg::fb_info_t);
  localparam int unsigned DATA_W = INFO_W + 2 * (QB + 1) + QB + 2 * AW;

  logic [qcn_cp_pkg::TARGET_W-1:0] target;
  logic [qcn_cp_pkg::WEIGHT_W-1:0] weight;

  logic                  accept;
  qcn_cp_pkg::fb_info_t  f_info;
  logic signed [QB:0]    f_offset;
  logic signed [QB:0]    f_delta;
  logic [QB-1:0]         f_q;

  logic [DATA_W-1:0]     wdata;
  logic [DATA_W-1:0]     rdata;
  logic                  rec_avail;
  logic                  rec_take;

  qcn_cp_pkg::fb_info_t  b_info;
  logic signed [QB:0]    b_offset;
  logic signed [QB:0]    b_delta;
  logic [QB-1:0]         b_q;
  logic [AW-1:0]         b_dst;
  logic [AW-1:0]         b_src;

  assign accept = push & ~full;

  qcn_cp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .target  (target),
    .weight  (weight)
  );

  qcn_cp_front #(.QB(QB)) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .mode         (mode),
    .packet_bytes (packet_bytes),
    .is_ipv4      (is_ipv4),
    .target       (target),
    .weight       (weight),
    .info         (f_info),
    .offset       (f_offset),
    .delta        (f_delta),
    .q_now        (f_q)
  );

  assign wdata = {f_info, f_offset, f_delta, f_q, dest_addr, src_addr};

  qcn_cp_fifo #(.DATA_W(DATA_W), .DEPTH(4)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (wdata),
    .pop       (rec_take),
    .rdata     (rdata),
    .full      (full),
    .not_empty (rec_avail)
  );

  assign {b_info, b_offset, b_delta, b_q, b_dst, b_src} = rdata;

  qcn_cp_back #(.QB(QB)) u_back (
    .clk             (clk),
    .rst             (rst),
    .rec_avail       (rec_avail),
    .rec_take        (rec_take),
    .info            (b_info),
    .offset          (b_offset),
    .delta           (b_delta),
    .q_now           (b_q),
    .dst             (b_dst),
    .src             (b_src),
    .pop             (pop),
    .empty           (empty),
    .feedback_valid  (feedback_valid),
    .feedback_level  (feedback_level),
    .queue_offset    (queue_offset),
    .queue_delta     (queue_delta),
    .fb_dest_addr    (fb_dest_addr),
    .fb_src_addr     (fb_src_addr),
    .queue_bytes_now (queue_bytes_now)
  );

endmodule
`default_nettype wire

### hw/rtl/qcn_cp_regs.sv
// qcn_cp_regs: apb configuration registers (target queue bytes, derivative weight)
// depends on qcn_cp_pkg
`timescale 1ns / 1ps
`default_nettype none
module qcn_cp_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [qcn_cp_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [qcn_cp_pkg::PDATA_W-1:0]      pwdata,
  output logic      [qcn_cp_pkg::PDATA_W-1:0]      prdata,
  output logic                                     pready,
  output logic      [qcn_cp_pkg::TARGET_W-1:0]     target,
  output logic      [qcn_cp_pkg::WEIGHT_W-1:0]     weight
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= qcn_cp_pkg::TARGET_RESET;
      weight <= qcn_cp_pkg::WEIGHT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        qcn_cp_pkg::REG_TARGET: target <= pwdata[qcn_cp_pkg::TARGET_W-1:0];
        qcn_cp_pkg::REG_WEIGHT: weight <= pwdata[qcn_cp_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      qcn_cp_pkg::REG_TARGET:
        prdata = {{(qcn_cp_pkg::PDATA_W-qcn_cp_pkg::TARGET_W){1'b0}}, target};
      qcn_cp_pkg::REG_WEIGHT:
        prdata = {{(qcn_cp_pkg::PDATA_W-qcn_cp_pkg::WEIGHT_W){1'b0}}, weight};
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/qcn_cp_front.sv
// qcn_cp_front: queue byte count, feedback computation and byte-credit sampler
// updates state on each accepted request and builds its feedback record
// depends on qcn_cp_pkg
`timescale 1ns / 1ps
`default_nettype none
module qcn_cp_front #(
  parameter int unsigned QB = 20
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 accept,
  input  wire logic                                 mode,
  input  wire logic [qcn_cp_pkg::LEN_W-1:0]         packet_bytes,
  input  wire logic                                 is_ipv4,
  input  wire logic [qcn_cp_pkg::TARGET_W-1:0]      target,
  input  wire logic [qcn_cp_pkg::WEIGHT_W-1:0]      weight,
  output qcn_cp_pkg::fb_info_t                      info,
  output logic signed [QB:0]                        offset,
  output logic signed [QB:0]                        delta,
  output logic        [QB-1:0]                      q_now
);

  localparam int unsigned SW = QB + 6;
  localparam int unsigned CW = qcn_cp_pkg::CREDIT_W;

  logic [QB-1:0]      queue_bytes;
  logic [QB-1:0]      queue_bytes_at_sample;
  logic [CW-1:0]      sample_credit;
  logic               feedback_pending;

  logic [QB-1:0]      queue_bytes_next;
  logic [QB-1:0]      queue_bytes_at_sample_next;
  logic [CW-1:0]      sample_credit_next;
  logic               feedback_pending_next;

  logic [QB-1:0]      len_q;
  logic [QB:0]        q_sum;
  logic [QB-1:0]      q_arr;
  logic [QB-1:0]      q_dep;
  logic               arrival;

  logic signed [SW-1:0] q_s, qold_s, qeq_s, off_s, dlt_s, wdlt_s, fb_s;
  logic signed [SW-1:0] floor_s, clamp_s, mag_s, dout_s;
  logic [19:0]        floor_mag;
  logic [qcn_cp_pkg::LEVEL_W-1:0] level;
  logic [CW:0]        credit_diff;
  logic               credit_neg;
  logic               arm;
  logic               emit;

  assign arrival = (mode == qcn_cp_pkg::MODE_ARRIVAL);
  assign len_q   = QB'(packet_bytes);
  assign q_sum   = {1'b0, queue_bytes} + {1'b0, len_q};
  assign q_arr   = q_sum[QB] ? {QB{1'b1}} : q_sum[QB-1:0];
  assign q_dep   = (queue_bytes > len_q) ? (queue_bytes - len_q) : '0;

  always_comb begin
    queue_bytes_next = arrival ? q_arr : q_dep;

    q_s    = signed'(SW'(queue_bytes_next));
    qold_s = signed'(SW'(queue_bytes_at_sample));
    qeq_s  = signed'(SW'(target));
    off_s  = qeq_s - q_s;
    dlt_s  = q_s - qold_s;
    // weight is three bits: shift-and-add
    wdlt_s = (weight[0] ? dlt_s : '0) + (weight[1] ? (dlt_s <<< 1) : '0)
           + (weight[2] ? (dlt_s <<< 2) : '0);
    fb_s   = off_s - wdlt_s;

    floor_mag = 20'(target) * 20'({weight, 1'b1});
    floor_s   = -signed'(SW'(floor_mag));
    if (fb_s < floor_s) begin
      clamp_s = floor_s;
    end else if (fb_s > 0) begin
      clamp_s = '0;
    end else begin
      clamp_s = fb_s;
    end
    mag_s = -clamp_s;
    level = mag_s[qcn_cp_pkg::LEVEL_LSB +: qcn_cp_pkg::LEVEL_W];

    credit_diff = {1'b0, sample_credit} - (CW+1)'(packet_bytes);
    credit_neg  = credit_diff[CW];

    queue_bytes_at_sample_next = queue_bytes_at_sample;
    sample_credit_next         = sample_credit;
    feedback_pending_next      = feedback_pending;
    arm  = 1'b0;
    emit = 1'b0;
    if (arrival) begin
      if (credit_neg) begin
        arm                        = (level != '0);
        queue_bytes_at_sample_next = queue_bytes_next;
        sample_credit_next         = qcn_cp_pkg::credit_reload(level[5:3]);
      end else begin
        sample_credit_next = credit_diff[CW-1:0];
      end
      emit = is_ipv4 & (feedback_pending | arm);
      feedback_pending_next = (feedback_pending | arm) & ~emit;
    end

    // delta goes out against the sample taken by this packet, if any
    dout_s = q_s - signed'(SW'(queue_bytes_at_sample_next));
  end

  assign info.valid = emit;
  assign info.level = level;
  assign offset     = off_s[QB:0];
  assign delta      = dout_s[QB:0];
  assign q_now      = queue_bytes_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_bytes           <= '0;
      queue_bytes_at_sample <= '0;
      sample_credit         <= qcn_cp_pkg::CREDIT_RESET;
      feedback_pending      <= 1'b0;
    end else if (accept) begin
      queue_bytes           <= queue_bytes_next;
      queue_bytes_at_sample <= queue_bytes_at_sample_next;
      sample_credit         <= sample_credit_next;
      feedback_pending      <= feedback_pending_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/qcn_cp_fifo.sv
// qcn_cp_fifo: short record queue between the front and the back
// DEPTH must be a power of two; no package dependencies
`timescale 1ns / 1ps
`default_nettype none
module qcn_cp_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              pop,
  output logic      [DATA_W-1:0] rdata,
  output logic                   full,
  output logic                   not_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/qcn_cp_back.sv
// qcn_cp_back: result register; saturates offset, delta and queue length to
// the result widths; zeroes all but queue length if no feedback goes out
// depends on qcn_cp_pkg
`timescale 1ns / 1ps
`default_nettype none
module qcn_cp_back #(
  parameter int unsigned QB = 20
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    rec_avail,
  output logic                                         rec_take,
  input  wire qcn_cp_pkg::fb_info_t                    info,
  input  wire logic signed [QB:0]                      offset,
  input  wire logic signed [QB:0]                      delta,
  input  wire logic        [QB-1:0]                    q_now,
  input  wire logic [qcn_cp_pkg::ADDR_W-1:0]           dst,
  input  wire logic [qcn_cp_pkg::ADDR_W-1:0]           src,
  input  wire logic                                    pop,
  output logic                                         empty,
  output logic                                         feedback_valid,
  output logic [qcn_cp_pkg::LEVEL_W-1:0]               feedback_level,
  output logic signed [qcn_cp_pkg::OUT_S_W-1:0]        queue_offset,
  output logic signed [qcn_cp_pkg::OUT_S_W-1:0]        queue_delta,
  output logic [qcn_cp_pkg::ADDR_W-1:0]                fb_dest_addr,
  output logic [qcn_cp_pkg::ADDR_W-1:0]                fb_src_addr,
  output logic [qcn_cp_pkg::OUT_Q_W-1:0]               queue_bytes_now
);

  localparam int unsigned SOW = qcn_cp_pkg::OUT_S_W;
  localparam int unsigned OQW = qcn_cp_pkg::OUT_Q_W;
  localparam int unsigned EW  = (QB + 1 > SOW) ? QB + 1 : SOW;
  localparam int unsigned QW  = (QB > OQW) ? QB : OQW;
  localparam logic signed [EW-1:0] S_MAX = EW'(21'sh0FFFFF);
  localparam logic signed [EW-1:0] S_MIN = EW'(21'sh100000);
  localparam logic [QW-1:0]        Q_MAX = QW'({OQW{1'b1}});

  logic                  out_valid;
  logic signed [EW-1:0]  off_e, dlt_e;
  logic signed [SOW-1:0] off_sat, dlt_sat;
  logic [QW-1:0]         q_e;
  logic [OQW-1:0]        q_sat;

  assign empty    = ~out_valid;
  assign rec_take = rec_avail & (~out_valid | pop);

  always_comb begin
    off_e = EW'(offset);
    dlt_e = EW'(delta);
    if (off_e > S_MAX) begin
      off_sat = S_MAX[SOW-1:0];
    end else if (off_e < S_MIN) begin
      off_sat = S_MIN[SOW-1:0];
    end else begin
      off_sat = off_e[SOW-1:0];
    end
    if (dlt_e > S_MAX) begin
      dlt_sat = S_MAX[SOW-1:0];
    end else if (dlt_e < S_MIN) begin
      dlt_sat = S_MIN[SOW-1:0];
    end else begin
      dlt_sat = dlt_e[SOW-1:0];
    end
    q_e   = QW'(q_now);
    q_sat = (q_e > Q_MAX) ? {OQW{1'b1}} : q_e[OQW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      feedback_valid  <= info.valid;
      feedback_level  <= info.valid ? info.level : '0;
      queue_offset    <= info.valid ? off_sat : '0;
      queue_delta     <= info.valid ? dlt_sat : '0;
      fb_dest_addr    <= info.valid ? dst : '0;
      fb_src_addr     <= info.valid ? src : '0;
      queue_bytes_now <= q_sat;
    end
  end

endmodule
`default_nettype wire
